>>> rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

   // Field widths of the request, response and configuration beats.
   localparam int TOTAL_W  = 18;
   localparam int INDEX_W  = 17;
   localparam int STATUS_W = 2;

   // Largest block count that the block number field can express.
   localparam int FIELD_LIMIT = 131072;

   // Reset value of the managed block count.
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(102400);

   // Default sizing of the used map.
   localparam int MAX_BLOCKS_DEF = 131072;
   localparam int WORD_BITS_DEF  = 32;

   // Action codes.
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd3;

   // Flags that the word unit reports to the sequencer for the current word.
   typedef struct packed {
      logic past_limit;  // current word starts at or beyond the limit
      logic avail_any;   // some managed block in the word is free
      logic in_word;     // the block to free lies in the current word
      logic hit_set;     // that block is currently marked used
   } bba_flags_type;

endpackage

>>> rtl/bba_if.sv
`timescale 1ns / 1ps

// Request channel: one allocate or free command per beat.
interface bba_req_if
   import bba_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               action;
   logic [INDEX_W-1:0] block_index;

   modport source (output valid, output action, output block_index, input ready);
   modport sink   (input valid, input action, input block_index, output ready);
endinterface

// Response channel: one result per request beat.
interface bba_rsp_if
   import bba_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  block_number;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output block_number, output status, input ready);
   modport sink   (input valid, input block_number, input status, output ready);
endinterface

>>> rtl/bba_ram.sv
`timescale 1ns / 1ps

module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bba_word_unit.sv
`timescale 1ns / 1ps

module bba_word_unit
   import bba_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int CMP_W     = 21
) (
   input  logic                          is_free,
   input  logic [WORD_BITS-1:0]          rd_word,
   input  logic [CMP_W-1:0]              base,
   input  logic [TOTAL_W-1:0]            lim,
   input  logic [INDEX_W-1:0]            idx,
   output bba_flags_type                 flags,
   output logic [$clog2(WORD_BITS)-1:0]  alloc_bit,
   output logic [WORD_BITS-1:0]          new_word
);

   localparam int BW = $clog2(WORD_BITS);

   logic [CMP_W:0]         operand;
   logic [CMP_W:0]         diff;
   logic [CMP_W-1:0]       diff_low;
   logic                   diff_neg;
   logic [WORD_BITS-1:0]   valid_mask;
   logic [WORD_BITS-1:0]   free_mask;
   logic [WORD_BITS-1:0]   avail;
   logic [WORD_BITS-1:0]   lowest;
   logic [BW-1:0]          bit_acc;

   // The one shared subtractor: distance from the word base to the limit
   // for an allocate, or to the block being freed for a free.
   assign operand  = is_free ? (CMP_W+1)'(idx) : (CMP_W+1)'(lim);
   assign diff     = operand - {1'b0, base};
   assign diff_neg = diff[CMP_W];
   assign diff_low = diff[CMP_W-1:0];

   // Per-bit masks: blocks below the limit, and the one block to free.
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         valid_mask[i] = CMP_W'(i) < diff_low;
         free_mask[i]  = diff_low == CMP_W'(i);
      end
   end

   // Isolate the lowest free block and encode its position.
   assign avail  = ~rd_word & valid_mask;
   assign lowest = avail & (~avail + WORD_BITS'(1));

   always_comb begin
      bit_acc = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         bit_acc = bit_acc | (lowest[i] ? BW'(i) : BW'(0));
      end
   end

   assign alloc_bit = bit_acc;

   // Status flags for the sequencer.
   always_comb begin
      flags.past_limit = diff_neg || (diff_low == '0);
      flags.avail_any  = |avail;
      flags.in_word    = !diff_neg && (diff_low < CMP_W'(WORD_BITS));
      flags.hit_set    = |(rd_word & free_mask);
   end

   // Updated word: claim the lowest free block, or release the freed one.
   assign new_word = is_free ? (rd_word & ~free_mask) : (rd_word | lowest);

endmodule

>>> rtl/block_bitmap_allocator.sv
`timescale 1ns / 1ps
// An allocate scans the map word by word from word 0 and responds at the first word
// with a free block below the limit; a free scans to the word that holds its block.
// Out of blocks is reported once the scan reaches the limit; an out-of-range free is
// reported without a scan. One request at a time; the scan reads one map word per cycle,
// holding while the response register is full. Reset (synchronous) clears all MAP_WORDS
// words (4096 by default), taking no request meanwhile; csr writes are taken always.

module block_bitmap_allocator
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int WORD_BITS  = WORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   bba_req_if.sink            req_if,
   bba_rsp_if.source          rsp_if,
   input  logic               csr_we,
   input  logic [TOTAL_W-1:0] csr_wdata
);

   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW        = $clog2(WORD_BITS);
   localparam int BASE_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
   localparam int CMP_W     = (BASE_W > TOTAL_W) ? BASE_W : TOTAL_W;
   localparam logic [TOTAL_W-1:0] LIM_CAP =
      TOTAL_W'((MAX_BLOCKS < FIELD_LIMIT) ? MAX_BLOCKS : FIELD_LIMIT);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [AW-1:0]        w_ff, w_in;
   logic [CMP_W-1:0]     base_ff, base_in;
   logic                 free_ff, free_in;
   logic                 range_ff, range_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_number_ff, rsp_number_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [TOTAL_W-1:0]   lim;
   logic                 req_fire;
   logic                 out_free;
   logic                 resp_fire;
   logic [INDEX_W-1:0]   resp_number;
   logic [STATUS_W-1:0]  resp_status;
   logic                 step;
   logic [CMP_W-1:0]     blk_wide;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;

   bba_flags_type        flags;
   logic [BW-1:0]        alloc_bit;
   logic [WORD_BITS-1:0] new_word;

   // Used map storage.
   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Shared per-word compare and update unit.
   bba_word_unit #(
      .WORD_BITS (WORD_BITS),
      .CMP_W     (CMP_W)
   ) u_unit (
      .is_free   (free_ff),
      .rd_word   (ram_rdata),
      .base      (base_ff),
      .lim       (lim),
      .idx       (idx_ff),
      .flags     (flags),
      .alloc_bit (alloc_bit),
      .new_word  (new_word)
   );

   // Effective limit is the least of the register, the map size and the field range.
   assign lim = (total_ff < LIM_CAP) ? total_ff : LIM_CAP;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign blk_wide     = base_ff + CMP_W'(alloc_bit);

   // Sequencer: clearing pass, idle, and the word-by-word scan.
   always_comb begin
      state_in    = state_ff;
      w_in        = w_ff;
      base_in     = base_ff;
      free_in     = free_ff;
      range_in    = range_ff;
      idx_in      = idx_ff;
      resp_fire   = 1'b0;
      resp_number = '0;
      resp_status = STATUS_OK;
      step        = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = w_ff;
      ram_wdata   = new_word;
      ram_raddr   = w_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            w_in      = w_ff + AW'(1);
            if (w_ff == AW'(MAP_WORDS - 1)) begin
               w_in     = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_raddr = '0;
            if (req_fire) begin
               state_in = ST_SCAN;
               w_in     = '0;
               base_in  = '0;
               free_in  = (req_if.action == ACT_FREE);
               range_in = (req_if.action == ACT_FREE) &&
                          ({1'b0, req_if.block_index} >= lim);
               idx_in   = req_if.block_index;
            end
         end
         ST_SCAN: begin
            if (free_ff && range_ff) begin
               resp_fire   = out_free;
               resp_status = STATUS_RANGE;
            end else if (!free_ff) begin
               if (flags.past_limit) begin
                  resp_fire   = out_free;
                  resp_status = STATUS_FULL;
               end else if (flags.avail_any) begin
                  resp_fire   = out_free;
                  resp_number = blk_wide[INDEX_W-1:0];
                  ram_we      = out_free;
               end else begin
                  step = 1'b1;
               end
            end else begin
               if (flags.in_word) begin
                  resp_fire = out_free;
                  if (flags.hit_set) begin
                     ram_we = out_free;
                  end else begin
                     resp_status = STATUS_DOUBLE;
                  end
               end else begin
                  step = 1'b1;
               end
            end
            // Move on to the next word, reading it for the following cycle.
            if (step) begin
               w_in      = w_ff + AW'(1);
               base_in   = base_ff + CMP_W'(WORD_BITS);
               ram_raddr = w_ff + AW'(1);
            end
            if (resp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            w_in     = '0;
         end
      endcase
   end

   // Response output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_number_in = rsp_number_ff;
      rsp_status_in = rsp_status_ff;
      if (resp_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_number_in = resp_number;
         rsp_status_in = resp_status;
      end
   end

   // Configuration register write.
   assign total_in = csr_we ? csr_wdata : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= TOTAL_RESET;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      free_ff       <= free_in;
      range_ff      <= range_in;
      idx_ff        <= idx_in;
      rsp_number_ff <= rsp_number_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.block_number = rsp_number_ff;
   assign rsp_if.status       = rsp_status_ff;

   // A successful allocate never hands out a block at or beyond the limit.
   a_alloc_in_limit: assert property (@(posedge clock) disable iff (reset)
      (resp_fire && !free_ff && resp_status == STATUS_OK) |-> (blk_wide < CMP_W'(lim)))
      else $error("allocated block beyond the limit");

   // Every accepted request starts its scan at the first map word.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN && w_ff == '0 && base_ff == '0))
      else $error("scan did not start at word zero");

   // The map is written during a scan only together with a response.
   a_write_with_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && ram_we) |-> resp_fire)
      else $error("map written without a response");

   // Only a successful allocate carries a nonzero block number.
   a_number_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != STATUS_OK) |-> (rsp_if.block_number == '0))
      else $error("nonzero block number on a failed request");

endmodule
